FILE: rtl/core/smh128_pkg.sv
// constants and helpers for the two-lane 128-bit streaming hash
package smh128_pkg;

  localparam int unsigned LANE_W = 64;
  localparam int unsigned HALF_W = LANE_W / 2;

  localparam logic [LANE_W-1:0] SEED_LOW  = 64'h243F6A8885A308D3;
  localparam logic [LANE_W-1:0] SEED_HIGH = 64'h13198A2E03707344;
  localparam logic [LANE_W-1:0] FIN_MUL1  = 64'hBF58476D1CE4E5B9;
  localparam logic [LANE_W-1:0] FIN_MUL2  = 64'h94D049BB133111EB;
  localparam logic [LANE_W-1:0] GOLDEN    = 64'h9E3779B97F4A7C15;
  localparam logic [LANE_W-1:0] HIGH_MUL  = 64'hC2B2AE3D27D4EB4F;

  localparam logic [5:0] SHIFT_A = 6'd30;
  localparam logic [5:0] SHIFT_B = 6'd27;
  localparam logic [5:0] SHIFT_C = 6'd31;
  localparam logic [5:0] SHIFT_FOLD = 6'd17;

  function automatic logic [LANE_W-1:0] xor_shr(input logic [LANE_W-1:0] v,
                                                input logic [5:0] sh);
    return v ^ (v >> sh);
  endfunction

endpackage

FILE: rtl/core/two_lane_splitmix_hash128.sv
// top level of the two-lane 128-bit streaming hash
// Every 64-bit request folds into two lanes through five 64-bit multiplies, all done on one
// shared 32x32 multiplier: each 64-bit product is built from three partial products (low x low,
// low x high, high x low) and a further step that uses the result. A word with last needs two
// more finalizer passes and a transfer into the output register, after which the digest is
// offered on the output channel. The input is stalled while a word is being worked on; a digest
// waiting on the output holds up only the transfer of the next digest, and the input stays
// stalled while that transfer waits.
module two_lane_splitmix_hash128 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_word,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_low,
  output logic [63:0] out_digest_high
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FMUL1 = 3'd1;
  localparam logic [2:0] ST_FMUL2 = 3'd2;
  localparam logic [2:0] ST_WMUL  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  localparam logic [1:0] JOB_LOW  = 2'd0;
  localparam logic [1:0] JOB_HIGH = 2'd1;
  localparam logic [1:0] JOB_DL   = 2'd2;
  localparam logic [1:0] JOB_DH   = 2'd3;

  localparam logic [1:0] PH_LL  = 2'd0;
  localparam logic [1:0] PH_LH  = 2'd1;
  localparam logic [1:0] PH_HL  = 2'd2;
  localparam logic [1:0] PH_USE = 2'd3;

  localparam int unsigned W = smh128_pkg::LANE_W;
  localparam int unsigned H = smh128_pkg::HALF_W;

  logic [2:0]   state_r, state_nxt;
  logic [1:0]   job_r, job_nxt;
  logic [1:0]   phase_r, phase_nxt;
  logic [W-1:0] low_r, low_nxt;
  logic [W-1:0] high_r, high_nxt;
  logic [W-1:0] word_r, word_nxt;
  logic         last_r, last_nxt;
  logic [W-1:0] v_r, v_nxt;
  logic [W-1:0] acc_r, acc_nxt;
  logic [W-1:0] dl_r, dl_nxt;
  logic [W-1:0] dh_r, dh_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] out_low_r, out_low_nxt;
  logic [W-1:0] out_high_r, out_high_nxt;

  // shared multiplier operands
  logic [W-1:0] mul_opnd;
  logic [W-1:0] mul_const;
  logic [H-1:0] mul_a;
  logic [H-1:0] mul_b;
  logic [W-1:0] mul_p;
  logic [W-1:0] fin_val;
  logic [W-1:0] high_new;
  logic [W-1:0] dh_val;

  always_comb begin
    mul_opnd  = (state_r == ST_WMUL) ? word_r : v_r;
    mul_const = smh128_pkg::HIGH_MUL;
    if (state_r == ST_FMUL1) begin
      mul_const = smh128_pkg::FIN_MUL1;
    end else if (state_r == ST_FMUL2) begin
      mul_const = smh128_pkg::FIN_MUL2;
    end
    mul_a = (phase_r == PH_HL) ? mul_opnd[W-1:H] : mul_opnd[H-1:0];
    mul_b = (phase_r == PH_LH) ? mul_const[W-1:H] : mul_const[H-1:0];
  end

  assign mul_p = mul_a * mul_b;

  assign fin_val  = smh128_pkg::xor_shr(acc_r, smh128_pkg::SHIFT_C);
  assign high_new = fin_val ^ (low_r >> smh128_pkg::SHIFT_FOLD);
  assign dh_val   = fin_val ^ low_r;

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    phase_nxt     = phase_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    word_nxt      = word_r;
    last_nxt      = last_r;
    v_nxt         = v_r;
    acc_nxt       = acc_r;
    dl_nxt        = dl_r;
    dh_nxt        = dh_r;
    out_valid_nxt = out_valid_r;
    out_low_nxt   = out_low_r;
    out_high_nxt  = out_high_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          word_nxt  = in_word;
          last_nxt  = in_last;
          v_nxt     = smh128_pkg::xor_shr(low_r ^ in_word, smh128_pkg::SHIFT_A);
          job_nxt   = JOB_LOW;
          phase_nxt = PH_LL;
          state_nxt = ST_FMUL1;
        end
      end
      ST_FMUL1, ST_FMUL2, ST_WMUL: begin
        phase_nxt = phase_r + 2'd1;
        unique case (phase_r)
          PH_LL: begin
            acc_nxt = mul_p;
          end
          PH_LH, PH_HL: begin
            // only the low half of the cross products lands inside 64 bits
            acc_nxt = {acc_r[W-1:H] + mul_p[H-1:0], acc_r[H-1:0]};
          end
          PH_USE: begin
            phase_nxt = PH_LL;
            if (state_r == ST_FMUL1) begin
              v_nxt     = smh128_pkg::xor_shr(acc_r, smh128_pkg::SHIFT_B);
              state_nxt = ST_FMUL2;
            end else if (state_r == ST_WMUL) begin
              v_nxt     = smh128_pkg::xor_shr(high_r + acc_r, smh128_pkg::SHIFT_A);
              state_nxt = ST_FMUL1;
            end else begin
              unique case (job_r)
                JOB_LOW: begin
                  low_nxt   = fin_val + smh128_pkg::GOLDEN;
                  job_nxt   = JOB_HIGH;
                  state_nxt = ST_WMUL;
                end
                JOB_HIGH: begin
                  high_nxt = high_new;
                  if (last_r) begin
                    v_nxt     = smh128_pkg::xor_shr(low_r ^ high_new, smh128_pkg::SHIFT_A);
                    job_nxt   = JOB_DL;
                    state_nxt = ST_FMUL1;
                  end else begin
                    state_nxt = ST_IDLE;
                  end
                end
                JOB_DL: begin
                  dl_nxt    = fin_val;
                  v_nxt     = smh128_pkg::xor_shr(high_r + smh128_pkg::GOLDEN,
                                                  smh128_pkg::SHIFT_A);
                  job_nxt   = JOB_DH;
                  state_nxt = ST_FMUL1;
                end
                JOB_DH: begin
                  dh_nxt = dh_val;
                  // all-zero digest gets its low half forced to one
                  if (dl_r == '0 && dh_val == '0) begin
                    dl_nxt = {{(W-1){1'b0}}, 1'b1};
                  end
                  low_nxt   = smh128_pkg::SEED_LOW;
                  high_nxt  = smh128_pkg::SEED_HIGH;
                  state_nxt = ST_EMIT;
                end
              endcase
            end
          end
        endcase
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_low_nxt   = dl_r;
          out_high_nxt  = dh_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      job_r       <= JOB_LOW;
      phase_r     <= PH_LL;
      low_r       <= smh128_pkg::SEED_LOW;
      high_r      <= smh128_pkg::SEED_HIGH;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      phase_r     <= phase_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    last_r     <= last_nxt;
    v_r        <= v_nxt;
    acc_r      <= acc_nxt;
    dl_r       <= dl_nxt;
    dh_r       <= dh_nxt;
    out_low_r  <= out_low_nxt;
    out_high_r <= out_high_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_digest_low  = out_low_r;
  assign out_digest_high = out_high_r;

endmodule

FILE: tb/sv/two_lane_splitmix_hash128_tb.sv
// self-checking bench for the two-lane hash: streamed words, digests checked against a predictor
module two_lane_splitmix_hash128_tb;

  localparam int RANDOM_WORDS = 1450;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [63:0] word;
    logic        last;
  } word_req_t;

  typedef struct {
    logic [63:0] low;
    logic [63:0] high;
  } digest_t;

  // directed table, every row fed to the predictor and each closing row's digest checked
  localparam int N_DIRECTED = 15;
  localparam word_req_t DIRECTED [N_DIRECTED] = '{
    '{64'h0000_0000_0000_0000, 1'b1},  // single zero word straight after reset
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
    '{64'h0000_0000_0000_0001, 1'b0},
    '{64'h8000_0000_0000_0000, 1'b1},
    '{64'h243F_6A88_85A3_08D3, 1'b1},  // word equal to the low seed cancels the lane
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0},
    '{64'h5555_5555_5555_5555, 1'b0},
    '{64'hFFFF_FFFF_0000_0000, 1'b0},
    '{64'h0000_0000_FFFF_FFFF, 1'b0},
    '{64'h0000_0000_0000_0000, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
    '{64'h0123_4567_89AB_CDEF, 1'b1},
    '{64'h0123_4567_89AB_CDEF, 1'b1},  // repeat must give the same digest after reseed
    '{64'h0000_0000_0000_0000, 1'b0},
    '{64'h0000_0000_0000_0000, 1'b1}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_word = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_digest_low;
  logic [63:0] out_digest_high;

  logic [63:0] lane_lo = smh128_pkg::SEED_LOW;
  logic [63:0] lane_hi = smh128_pkg::SEED_HIGH;
  digest_t     pending_digests [$];
  int          mismatches = 0;
  int          idle_cycles = 0;

  two_lane_splitmix_hash128 DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word        (in_word),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digest_low (out_digest_low),
    .out_digest_high(out_digest_high)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] splitmix_finish(input logic [63:0] v);
    v = v ^ (v >> smh128_pkg::SHIFT_A);
    v = v * smh128_pkg::FIN_MUL1;
    v = v ^ (v >> smh128_pkg::SHIFT_B);
    v = v * smh128_pkg::FIN_MUL2;
    v = v ^ (v >> smh128_pkg::SHIFT_C);
    return v;
  endfunction

  // fold one accepted word into both lanes, queue the digest when it closes a message
  task automatic absorb_word(input logic [63:0] w, input logic l);
    digest_t d;
    lane_lo = splitmix_finish(lane_lo ^ w) + smh128_pkg::GOLDEN;
    lane_hi = splitmix_finish(lane_hi + w * smh128_pkg::HIGH_MUL)
              ^ (lane_lo >> smh128_pkg::SHIFT_FOLD);
    if (l) begin
      d.low  = splitmix_finish(lane_lo ^ lane_hi);
      d.high = splitmix_finish(lane_hi + smh128_pkg::GOLDEN) ^ lane_lo;
      if (d.low == '0 && d.high == '0) d.low = 64'd1;
      pending_digests.push_back(d);
      lane_lo = smh128_pkg::SEED_LOW;
      lane_hi = smh128_pkg::SEED_HIGH;
    end
  endtask

  function automatic logic [63:0] random_word();
    logic [63:0] bit_mask;
    bit_mask = 64'd1 << $urandom_range(0, 63);
    unique case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return bit_mask;
      3: return ~bit_mask;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_request(input logic [63:0] w, input logic l, input bit quiet);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    in_last  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_word(w, l);
  endtask

  // stimulus
  initial begin
    int  sent;
    int  msg_len;
    bit  quiet;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED[i]) send_request(DIRECTED[i].word, DIRECTED[i].last, 1'b0);
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      quiet   = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < msg_len; k++) begin
        send_request(random_word(), k == msg_len - 1, quiet);
        sent++;
      end
    end
    in_valid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // result side: random back-pressure, compare each digest with the oldest expected one
  initial begin
    int      hold;
    bit      quiet;
    digest_t want;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      quiet = ($urandom_range(0, 3) == 0);
      hold  = quiet ? 0 : $urandom_range(0, 13);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_digests.size() == 0) begin
        $display("%0t unexpected digest: expected none, got %h_%h", $time,
                 out_digest_high, out_digest_low);
        mismatches++;
      end else begin
        want = pending_digests.pop_front();
        if (out_digest_low !== want.low) begin
          $display("%0t digest_low: expected %h, got %h", $time, want.low, out_digest_low);
          mismatches++;
        end
        if (out_digest_high !== want.high) begin
          $display("%0t digest_high: expected %h, got %h", $time, want.high, out_digest_high);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t watchdog: no request accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

FILE: filelist.f
rtl/core/smh128_pkg.sv
rtl/core/two_lane_splitmix_hash128.sv
tb/sv/two_lane_splitmix_hash128_tb.sv
